// File: rtl/asui_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asui_pkg
// Shared codes and types for the set union / intersection block.
// ----------------------------------------------------------------------------
package asui_pkg;

	localparam int VALUE_W = 32;
	localparam int FUNC_W  = 3;

	// request codes carried on the func field
	localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_APPEND_A  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_APPEND_B  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_UNION     = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_INTERSECT = 3'd4;

	// one event from the sequencer to the result stage
	typedef struct packed {
		logic               fin;      // end of request, no element
		logic               dropped;  // sticky overflow flag at request time
		logic [VALUE_W-1:0] value;    // element value when fin is low
	} asui_ev_t;

endpackage

// File: rtl/asui_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asui_core
// List memories, counts and the compare sequencer for union / intersection.
// ----------------------------------------------------------------------------
module asui_core #(
	parameter int LIST_DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [asui_pkg::FUNC_W-1:0]          func,
	input  logic signed [asui_pkg::VALUE_W-1:0]  value,
	output logic                                 ev_valid,
	input  logic                                 ev_ready,
	output asui_pkg::asui_ev_t                   ev
);

	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_RD   = 6'b000010,
		ST_KEY  = 6'b000100,
		ST_SCAN = 6'b001000,
		ST_EMIT = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t                         state_q;
	logic [CW-1:0]                  count_a_q, count_b_q;
	logic                           ovf_q;
	logic                           is_union_q;
	logic                           phase_b_q;   // outer loop walks list B
	logic                           scan_b_q;    // scan walks list B
	logic                           scan2_q;     // union: second scan, earlier B
	logic [CW-1:0]                  i_q, j_q;
	logic [asui_pkg::VALUE_W-1:0]   key_q;
	logic                           rd_v_s1;

	logic [asui_pkg::VALUE_W-1:0]   mem_a [LIST_DEPTH];
	logic [asui_pkg::VALUE_W-1:0]   mem_b [LIST_DEPTH];
	logic [asui_pkg::VALUE_W-1:0]   rdata_a_s1, rdata_b_s1;

	logic                           in_fire;
	logic                           wr_a, wr_b;
	logic [CW-1:0]                  outer_cnt, scan_lim;
	logic [asui_pkg::VALUE_W-1:0]   scan_data;
	logic                           match, scan_more, outer_more;
	logic                           rd_a_en, rd_b_en;
	logic [AW-1:0]                  rd_a_addr, rd_b_addr;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;

	assign wr_a = in_fire && (func == asui_pkg::FUNC_APPEND_A) && (count_a_q < DEPTH_C);
	assign wr_b = in_fire && (func == asui_pkg::FUNC_APPEND_B) && (count_b_q < DEPTH_C);

	assign outer_cnt  = phase_b_q ? count_b_q : count_a_q;
	assign outer_more = (i_q < outer_cnt);
	assign scan_lim   = scan_b_q ? (scan2_q ? i_q : count_b_q) : count_a_q;
	assign scan_more  = (j_q < scan_lim);
	assign scan_data  = scan_b_q ? rdata_b_s1 : rdata_a_s1;
	assign match      = rd_v_s1 && (scan_data == key_q);

	always_comb begin
		rd_a_en   = 1'b0;
		rd_b_en   = 1'b0;
		rd_a_addr = j_q[AW-1:0];
		rd_b_addr = j_q[AW-1:0];
		case (state_q)
			ST_RD: begin
				rd_a_en   = outer_more && !phase_b_q;
				rd_b_en   = outer_more && phase_b_q;
				rd_a_addr = i_q[AW-1:0];
				rd_b_addr = i_q[AW-1:0];
			end
			ST_SCAN: begin
				rd_a_en = !match && scan_more && !scan_b_q;
				rd_b_en = !match && scan_more && scan_b_q;
			end
			default: begin
			end
		endcase
	end

	// list storage: one write port at the fill count, one registered read port
	always_ff @(posedge clk) begin
		if (wr_a)
			mem_a[count_a_q[AW-1:0]] <= value;
		if (rd_a_en)
			rdata_a_s1 <= mem_a[rd_a_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_b)
			mem_b[count_b_q[AW-1:0]] <= value;
		if (rd_b_en)
			rdata_b_s1 <= mem_b[rd_b_addr];
	end

	assign ev_valid    = (state_q == ST_EMIT) || (state_q == ST_FIN);
	assign ev.fin      = (state_q == ST_FIN);
	assign ev.dropped  = ovf_q;
	assign ev.value    = key_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_KEY)
			key_q <= phase_b_q ? rdata_b_s1 : rdata_a_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_a_q  <= '0;
			count_b_q  <= '0;
			ovf_q      <= 1'b0;
			is_union_q <= 1'b0;
			phase_b_q  <= 1'b0;
			scan_b_q   <= 1'b0;
			scan2_q    <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			rd_v_s1    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (func)
							asui_pkg::FUNC_CLEAR: begin
								count_a_q <= '0;
								count_b_q <= '0;
								ovf_q     <= 1'b0;
							end
							asui_pkg::FUNC_APPEND_A: begin
								if (wr_a)
									count_a_q <= count_a_q + 1'b1;
								else
									ovf_q <= 1'b1;
							end
							asui_pkg::FUNC_APPEND_B: begin
								if (wr_b)
									count_b_q <= count_b_q + 1'b1;
								else
									ovf_q <= 1'b1;
							end
							asui_pkg::FUNC_UNION: begin
								is_union_q <= 1'b1;
								phase_b_q  <= 1'b0;
								i_q        <= '0;
								state_q    <= ST_RD;
							end
							asui_pkg::FUNC_INTERSECT: begin
								is_union_q <= 1'b0;
								phase_b_q  <= 1'b0;
								i_q        <= '0;
								state_q    <= ST_RD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RD: begin
					if (outer_more) begin
						state_q <= ST_KEY;
					end else if (is_union_q && !phase_b_q) begin
						phase_b_q <= 1'b1;
						i_q       <= '0;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_KEY: begin
					j_q     <= '0;
					rd_v_s1 <= 1'b0;
					scan2_q <= 1'b0;
					if (is_union_q && !phase_b_q) begin
						state_q <= ST_EMIT;
					end else begin
						// union checks B against A first; intersection scans B
						scan_b_q <= !is_union_q;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (match) begin
						rd_v_s1 <= 1'b0;
						if (is_union_q) begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_RD;
						end else begin
							state_q <= ST_EMIT;
						end
					end else if (!scan_more) begin
						rd_v_s1 <= 1'b0;
						if (is_union_q && !scan2_q) begin
							// a B element equal to any earlier B element is
							// already out, either taken or found in A
							scan_b_q <= 1'b1;
							scan2_q  <= 1'b1;
							j_q      <= '0;
						end else if (is_union_q) begin
							state_q <= ST_EMIT;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_RD;
						end
					end else begin
						rd_v_s1 <= 1'b1;
						j_q     <= j_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (ev_ready) begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_FIN: begin
					if (ev_ready)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/asui_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asui_out
// Holds one element back to mark the last word, and drives the result port.
// ----------------------------------------------------------------------------
module asui_out (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 ev_valid,
	output logic                                 ev_ready,
	input  asui_pkg::asui_ev_t                   ev,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [asui_pkg::VALUE_W-1:0]  value_res,
	output logic                                 valid_res,
	output logic                                 last,
	output logic                                 dropped
);

	logic                           pend_v_q;
	logic [asui_pkg::VALUE_W-1:0]   pend_value_q;
	logic                           pend_drop_q;

	logic                           out_valid_q;
	logic [asui_pkg::VALUE_W-1:0]   value_q;
	logic                           valid_res_q, last_q, dropped_q;

	logic out_free, ev_fire, load_out;

	assign out_free = !out_valid_q || out_ready;
	assign ev_ready = ev.fin ? out_free : (!pend_v_q || out_free);
	assign ev_fire  = ev_valid && ev_ready;
	assign load_out = ev_fire && (ev.fin || pend_v_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ev_fire)
				pend_v_q <= !ev.fin;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_fire && !ev.fin) begin
			pend_value_q <= ev.value;
			pend_drop_q  <= ev.dropped;
		end
		if (load_out) begin
			if (pend_v_q) begin
				value_q     <= pend_value_q;
				valid_res_q <= 1'b1;
				dropped_q   <= pend_drop_q;
			end else begin
				value_q     <= '0;
				valid_res_q <= 1'b0;
				dropped_q   <= ev.dropped;
			end
			last_q <= ev.fin;
		end
	end

	assign out_valid = out_valid_q;
	assign value_res = value_q;
	assign valid_res = valid_res_q;
	assign last      = last_q;
	assign dropped   = dropped_q;

endmodule

// File: rtl/array_set_union_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_set_union_intersection
// Two stored lists of signed words with union and intersection requests.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_ready, func, value): func clear empties both
// lists and the drop flag, append A / append B store value at the list tail
// (a full list drops the word and sets the sticky drop flag), union and
// intersection start a request. Unused func codes are ignored.
// Output channel (out_valid / out_ready): one word per result element; last
// marks the final word of a request, and an empty answer gives a single word
// with valid_res low. dropped reports the drop flag at request time.
// Clear and append give no word. A request walks the lists in two block
// RAMs (one registered read port each): a union emits each A element as
// read, then checks each B element against A and against the earlier B
// elements and emits it if no match is found; an intersection scans B for
// each A element and emits it on a match. The compare scans run linearly
// over the RAM read port.
// in_ready is low while a request runs.
// One element is held back so last can be set; a stalled receiver stalls the
// sequencer. Reset empties both lists and clears the drop flag; list RAM
// contents are not cleared.
// ----------------------------------------------------------------------------
module array_set_union_intersection #(
	parameter int LIST_DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [asui_pkg::FUNC_W-1:0]          func,
	input  logic signed [asui_pkg::VALUE_W-1:0]  value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [asui_pkg::VALUE_W-1:0]  value_res,
	output logic                                 valid_res,
	output logic                                 last,
	output logic                                 dropped
);

	// sequencer to result stage
	logic               ev_valid;
	logic               ev_ready;
	asui_pkg::asui_ev_t ev;

	// list RAMs, counts and compare sequencer
	asui_core #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.value    (value),
		.ev_valid (ev_valid),
		.ev_ready (ev_ready),
		.ev       (ev)
	);

	// hold back one element, mark last, register the output word
	asui_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (ev_valid),
		.ev_ready  (ev_ready),
		.ev        (ev),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value_res (value_res),
		.valid_res (valid_res),
		.last      (last),
		.dropped   (dropped)
	);

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the set union / intersection block.
// ----------------------------------------------------------------------------
// A shadow copy of both lists and the sticky drop flag is updated each time
// the block takes an input word. Union and intersection requests turn that
// copy into the answer words they should produce, which wait in a queue.
// Every output word is compared field by field with the oldest waiting one.
// Stimulus runs from a short directed part through random list sequences,
// full and overflowing lists, a long receiver stall and random noise. Both
// sides draw random stalls, with occasional stall-free bursts.
// ----------------------------------------------------------------------------
module testbench;
	import asui_pkg::*;

	localparam int DEPTH       = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 64;

	// one answer word as the block should present it
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               valid;
		logic               last;
		logic               dropped;
	} answer_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [FUNC_W-1:0]          func;
	logic signed [VALUE_W-1:0]  value;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [VALUE_W-1:0]  value_res;
	logic                       valid_res;
	logic                       last;
	logic                       dropped;

	// shadow of the block's lists and flag
	logic [VALUE_W-1:0] held_a [DEPTH];
	logic [VALUE_W-1:0] held_b [DEPTH];
	int                 held_cnt_a;
	int                 held_cnt_b;
	logic               drop_flag;

	answer_t            pending_words [$];
	answer_t            head;
	int                 error_count;

	// stall bookkeeping: sender in its task, receiver in its always block
	int                 tx_burst;
	int                 rx_gap;
	int                 rx_burst;
	logic               rx_hold;

	array_set_union_intersection #(
		.LIST_DEPTH(DEPTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value_res (value_res),
		.valid_res (valid_res),
		.last      (last),
		.dropped   (dropped)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// Shadow model
	// ------------------------------------------------------------------------

	function automatic logic holds_value(input logic [VALUE_W-1:0] lst [DEPTH],
			input int cnt, input logic [VALUE_W-1:0] v);
		for (int i = 0; i < cnt; i++)
			if (lst[i] == v)
				return 1'b1;
		return 1'b0;
	endfunction

	// Apply one accepted input word to the shadow and queue the answer words.
	function automatic void apply_request(input logic [FUNC_W-1:0] f,
			input logic [VALUE_W-1:0] v);
		answer_t words [$];
		logic    taken [DEPTH];
		logic    seen;
		foreach (taken[i])
			taken[i] = 1'b0;
		case (f)
			FUNC_CLEAR: begin
				held_cnt_a = 0;
				held_cnt_b = 0;
				drop_flag  = 1'b0;
			end
			FUNC_APPEND_A: begin
				if (held_cnt_a < DEPTH) begin
					held_a[held_cnt_a] = v;
					held_cnt_a++;
				end else
					drop_flag = 1'b1;
			end
			FUNC_APPEND_B: begin
				if (held_cnt_b < DEPTH) begin
					held_b[held_cnt_b] = v;
					held_cnt_b++;
				end else
					drop_flag = 1'b1;
			end
			FUNC_UNION: begin
				// all of A, duplicates kept
				for (int i = 0; i < held_cnt_a; i++)
					words.push_back('{held_a[i], 1'b1, 1'b0, drop_flag});
				// B words whose value has not gone out yet
				for (int i = 0; i < held_cnt_b; i++) begin
					seen = holds_value(held_a, held_cnt_a, held_b[i]);
					for (int j = 0; j < i; j++)
						if (taken[j] && held_b[j] == held_b[i])
							seen = 1'b1;
					if (!seen) begin
						taken[i] = 1'b1;
						words.push_back('{held_b[i], 1'b1, 1'b0, drop_flag});
					end
				end
			end
			FUNC_INTERSECT: begin
				for (int i = 0; i < held_cnt_a; i++)
					if (holds_value(held_b, held_cnt_b, held_a[i]))
						words.push_back('{held_a[i], 1'b1, 1'b0, drop_flag});
			end
			default: ;
		endcase
		if (f == FUNC_UNION || f == FUNC_INTERSECT) begin
			// an empty answer still gives one marker word
			if (words.size() == 0)
				words.push_back('{'0, 1'b0, 1'b0, drop_flag});
			words[words.size()-1].last = 1'b1;
			foreach (words[i])
				pending_words.push_back(words[i]);
		end
	endfunction

	// Draw a value: extremes, small values that collide, copies of stored
	// words so that matches and duplicates are common, or anything at all.
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2, 3: return (held_cnt_a > 0) ? held_a[$urandom_range(0, held_cnt_a-1)]
				: 32'(int'($urandom_range(0, 6)) - 3);
			4: return (held_cnt_b > 0) ? held_b[$urandom_range(0, held_cnt_b-1)]
				: 32'(int'($urandom_range(0, 6)) - 3);
			5, 6: return 32'(int'($urandom_range(0, 6)) - 3);
			default: return $urandom();
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------

	// Offer one word after a random gap; hold it until taken, then predict.
	task automatic send_word(input logic [FUNC_W-1:0] f, input logic [VALUE_W-1:0] v);
		int gap;
		if (tx_burst > 0) begin
			gap = 0;
			tx_burst--;
		end else begin
			gap = $urandom_range(0, 4);
			if ($urandom_range(0, 15) == 0)
				tx_burst = $urandom_range(8, 24);
		end
		// drop valid only when a gap follows, so valid never toggles in one step
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		value    <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		apply_request(f, v);
	endtask

	// Release the input; always follow with at least one clock edge.
	task automatic idle_input();
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Receiver and checker
	// ------------------------------------------------------------------------

	// Sample at the edge, compare against the oldest expectation, then decide
	// whether to stall the next word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_words.size() == 0) begin
					$display("%0t: unexpected word value %0d valid %0b last %0b dropped %0b",
						$time, value_res, valid_res, last, dropped);
					error_count++;
				end else begin
					head = pending_words.pop_front();
					if (value_res !== head.value) begin
						$display("%0t: value_res expected %0d actual %0d",
							$time, $signed(head.value), value_res);
						error_count++;
					end
					if (valid_res !== head.valid) begin
						$display("%0t: valid_res expected %0b actual %0b",
							$time, head.valid, valid_res);
						error_count++;
					end
					if (last !== head.last) begin
						$display("%0t: last expected %0b actual %0b",
							$time, head.last, last);
						error_count++;
					end
					if (dropped !== head.dropped) begin
						$display("%0t: dropped expected %0b actual %0b",
							$time, head.dropped, dropped);
						error_count++;
					end
				end
				if (rx_burst > 0) begin
					rx_gap = 0;
					rx_burst--;
				end else begin
					rx_gap = $urandom_range(0, 4);
					if ($urandom_range(0, 15) == 0)
						rx_burst = $urandom_range(8, 32);
				end
			end
			if (rx_hold || rx_gap > 0) begin
				out_ready <= 1'b0;
				if (!rx_hold)
					rx_gap--;
			end else
				out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Requests on empty lists, unused codes, one list empty.
	task automatic test_empty_and_unused();
		send_word(FUNC_UNION, '0);
		send_word(FUNC_INTERSECT, '1);
		send_word(3'd5, '1);
		send_word(3'd6, '0);
		send_word(3'd7, 32'h8000_0000);
		send_word(FUNC_APPEND_B, 32'd7);
		send_word(FUNC_APPEND_B, 32'hffff_fff9);
		send_word(FUNC_UNION, '0);
		send_word(FUNC_INTERSECT, '0);
	endtask

	// Extreme values with duplicates inside A and across both lists.
	task automatic test_extreme_values();
		send_word(FUNC_CLEAR, '1);
		send_word(FUNC_APPEND_A, 32'h8000_0000);
		send_word(FUNC_APPEND_A, 32'h7fff_ffff);
		send_word(FUNC_APPEND_A, '0);
		send_word(FUNC_APPEND_A, 32'h8000_0000);
		send_word(FUNC_APPEND_B, '1);
		send_word(FUNC_APPEND_B, 32'h7fff_ffff);
		send_word(FUNC_APPEND_B, '1);
		send_word(FUNC_APPEND_B, '0);
		send_word(FUNC_UNION, '0);
		send_word(FUNC_INTERSECT, '0);
	endtask

	// Well-formed sequences: clear, a random fill of both lists, requests.
	task automatic test_random_lists(input int rounds);
		int na;
		int nb;
		repeat (rounds) begin
			send_word(FUNC_CLEAR, pick_value());
			na = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 6);
			nb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 6);
			while (na > 0 || nb > 0) begin
				if (na > 0 && (nb == 0 || $urandom_range(0, 1))) begin
					send_word(FUNC_APPEND_A, pick_value());
					na--;
				end else begin
					send_word(FUNC_APPEND_B, pick_value());
					nb--;
				end
				// now and then ask in the middle of a fill
				if ($urandom_range(0, 11) == 0)
					send_word($urandom_range(0, 1) ? FUNC_UNION : FUNC_INTERSECT, pick_value());
			end
			repeat ($urandom_range(1, 3))
				send_word($urandom_range(0, 1) ? FUNC_UNION : FUNC_INTERSECT, pick_value());
		end
	endtask

	// Fill both lists to the brim and past it. Disjoint lists give the
	// longest union; a reversed copy gives a full intersection.
	task automatic test_full_lists();
		logic [VALUE_W-1:0] base;
		for (int variant = 0; variant < 2; variant++) begin
			base = $urandom();
			send_word(FUNC_CLEAR, '0);
			for (int i = 0; i < DEPTH; i++)
				send_word(FUNC_APPEND_A, base + i);
			for (int i = 0; i < DEPTH; i++)
				send_word(FUNC_APPEND_B, variant ? base + (DEPTH - 1 - i) : base + 100 + i);
			send_word(FUNC_INTERSECT, '0);
			// overflow both lists: words dropped, flag sticks
			send_word(FUNC_APPEND_A, pick_value());
			send_word(FUNC_APPEND_B, pick_value());
			send_word(FUNC_UNION, '0);
			send_word(FUNC_INTERSECT, '0);
			// clear drops the flag again
			send_word(FUNC_CLEAR, '0);
			send_word(FUNC_APPEND_A, pick_value());
			send_word(FUNC_UNION, '0);
		end
	endtask

	// Hold the receiver off while requests keep coming so the block backs
	// up into its input; then pause the sender until everything drained.
	task automatic test_stall_pressure();
		send_word(FUNC_CLEAR, '0);
		repeat (6)
			send_word(FUNC_APPEND_A, pick_value());
		repeat (6)
			send_word(FUNC_APPEND_B, pick_value());
		fork
			begin
				@(posedge clk);
				rx_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		send_word(FUNC_UNION, '0);
		send_word(FUNC_APPEND_B, pick_value());
		send_word(FUNC_INTERSECT, '0);
		send_word(FUNC_UNION, '0);
		idle_input();
		wait_drained();
		send_word(FUNC_INTERSECT, '0);
	endtask

	// Random codes, unused ones included, with random values.
	task automatic test_mixed_noise(input int count);
		logic [FUNC_W-1:0] f;
		repeat (count) begin
			f = FUNC_W'($urandom_range(0, 7));
			// keep clears rare so the lists get somewhere
			if (f == FUNC_CLEAR && $urandom_range(0, 3) != 0)
				f = FUNC_APPEND_A;
			send_word(f, pick_value());
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		func        = FUNC_CLEAR;
		value       = '0;
		out_ready   = 1'b0;
		rx_hold     = 1'b0;
		rx_gap      = 0;
		rx_burst    = 0;
		tx_burst    = 0;
		held_cnt_a  = 0;
		held_cnt_b  = 0;
		drop_flag   = 1'b0;
		error_count = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_unused();
		test_extreme_values();
		test_random_lists(12);
		test_full_lists();
		test_stall_pressure();
		test_mixed_noise(40);
		test_random_lists(4);

		// let the last answers arrive, then watch for strays
		idle_input();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Give up if the run hangs.
	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
